// ===== design/two_class_sorted_value_list_assert.svh =====
// assertion macros used by the sorted value list datapath
`ifndef TWO_CLASS_SORTED_VALUE_LIST_ASSERT_SVH
`define TWO_CLASS_SORTED_VALUE_LIST_ASSERT_SVH
`ifndef SYNTHESIS
// checked on every clock edge, disabled while reset is low
`define TCSVL_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every clock edge, reset included
`define TCSVL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCSVL_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define TCSVL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/tcsvl_pkg.sv =====
// shared constants, types and helpers of the sorted value list
`timescale 1ns / 1ps
package tcsvl_pkg;

  // table size and derived widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned EVAL_W   = 13;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned ENTRY_W  = 16;
  localparam int unsigned CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // clamp limits
  localparam logic [VALUE_W-1:0] SIZE_MIN = 16'd5;
  localparam logic [VALUE_W-1:0] SIZE_MAX = 16'd6000;
  localparam logic [VALUE_W-1:0] DENS_MIN = 16'd1;
  localparam logic [VALUE_W-1:0] DENS_MAX = 16'd255;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic ins_setup;
    logic move;
    logic write_new;
    logic rd_issue;
    logic rd_take;
    logic count_dec;
    logic push;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic [OP_W-1:0] op;
    logic            in_idx_bad;
    logic            cnt_zero;
    logic            full;
    logic            scan_done;
    logic            scan_dup;
    logic            move_done;
  } st_t;

  // hold a raw value to the range of its class
  function automatic logic [EVAL_W-1:0] clamp_value(input logic dens,
                                                    input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [VALUE_W-1:0] res;
    lo = dens ? DENS_MIN : SIZE_MIN;
    hi = dens ? DENS_MAX : SIZE_MAX;
    if (raw < lo) begin
      res = lo;
    end else if (raw > hi) begin
      res = hi;
    end else begin
      res = raw;
    end
    return res[EVAL_W-1:0];
  endfunction

endpackage

// ===== design/tcsvl_if.sv =====
// valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
interface tcsvl_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcsvl_pkg::OP_W-1:0]     operation;
  logic                           is_density;
  logic [tcsvl_pkg::VALUE_W-1:0]  value;
  logic [tcsvl_pkg::IDX_W-1:0]    index;

  modport source (output valid, operation, is_density, value, index, input ready);
  modport sink   (input valid, operation, is_density, value, index, output ready);
endinterface

interface tcsvl_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcsvl_pkg::STATUS_W-1:0] status;
  logic                           entry_is_density;
  logic [tcsvl_pkg::EVAL_W-1:0]   entry_value;
  logic [tcsvl_pkg::POS_W-1:0]    position;
  logic [tcsvl_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, entry_is_density, entry_value, position,
                  entry_count, input ready);
  modport sink   (input valid, status, entry_is_density, entry_value, position,
                  entry_count, output ready);
endinterface

// ===== design/tcsvl_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module tcsvl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tcsvl_ctrl.sv =====
// sequencing state machine of the sorted value list
`timescale 1ns / 1ps
module tcsvl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tcsvl_pkg::st_t    st_i,
  output tcsvl_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_INS_DEC = 3'd2;
  localparam logic [2:0] S_MOVE    = 3'd3;
  localparam logic [2:0] S_WRNEW   = 3'd4;
  localparam logic [2:0] S_RDADDR  = 3'd5;
  localparam logic [2:0] S_RDDATA  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          unique case (st_i.in_op) inside
            tcsvl_pkg::OP_INSERT: begin
              state_d = st_i.cnt_zero ? S_INS_DEC : S_SCAN;
            end
            tcsvl_pkg::OP_DELETE, tcsvl_pkg::OP_READ: begin
              state_d = st_i.in_idx_bad ? S_DONE : S_RDADDR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.scan_done) begin
          state_d = st_i.scan_dup ? S_DONE : S_INS_DEC;
        end
      end
      S_INS_DEC: begin
        cmd_o.ins_setup = 1'b1;
        state_d = st_i.full ? S_DONE : S_MOVE;
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        if (st_i.move_done) begin
          if (st_i.op == tcsvl_pkg::OP_INSERT) begin
            state_d = S_WRNEW;
          end else begin
            cmd_o.count_dec = 1'b1;
            state_d = S_DONE;
          end
        end
      end
      S_WRNEW: begin
        cmd_o.write_new = 1'b1;
        state_d = S_DONE;
      end
      S_RDADDR: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_RDDATA;
      end
      S_RDDATA: begin
        cmd_o.rd_take = 1'b1;
        state_d = (st_i.op == tcsvl_pkg::OP_DELETE) ? S_MOVE : S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/tcsvl_dp.sv =====
// table storage, scan and shift datapath of the sorted value list
`timescale 1ns / 1ps
`include "two_class_sorted_value_list_assert.svh"
module tcsvl_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tcsvl_pkg::cmd_t                 cmd_i,
  output tcsvl_pkg::st_t                  st_o,
  input  logic [tcsvl_pkg::OP_W-1:0]      operation_i,
  input  logic                            is_density_i,
  input  logic [tcsvl_pkg::VALUE_W-1:0]   value_i,
  input  logic [tcsvl_pkg::IDX_W-1:0]     index_i,
  output logic [tcsvl_pkg::STATUS_W-1:0]  status_o,
  output logic                            entry_is_density_o,
  output logic [tcsvl_pkg::EVAL_W-1:0]    entry_value_o,
  output logic [tcsvl_pkg::POS_W-1:0]     position_o,
  output logic [tcsvl_pkg::COUNT_W-1:0]   entry_count_o
);

  localparam int unsigned ADDR_W  = tcsvl_pkg::ADDR_W;
  localparam int unsigned CNT_W   = tcsvl_pkg::CNT_W;
  localparam int unsigned CMP_W   = tcsvl_pkg::CMP_W;
  localparam int unsigned ENTRY_W = tcsvl_pkg::ENTRY_W;
  localparam int unsigned EVAL_W  = tcsvl_pkg::EVAL_W;
  localparam int unsigned MAG_W   = ENTRY_W - 1;

  // captured request
  logic [tcsvl_pkg::OP_W-1:0]  op_q, op_d;
  logic                        dens_q, dens_d;
  logic [EVAL_W-1:0]           val_q, val_d;
  logic [tcsvl_pkg::IDX_W-1:0] idx_q, idx_d;

  // table control
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] ridx_q, ridx_d;
  logic             rvalid_q, rvalid_d;

  // pending result and output register
  logic [tcsvl_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                           res_dens_q, res_dens_d;
  logic [EVAL_W-1:0]              res_val_q, res_val_d;
  logic [tcsvl_pkg::POS_W-1:0]    res_pos_q, res_pos_d;
  logic [tcsvl_pkg::STATUS_W-1:0] out_status_q;
  logic                           out_dens_q;
  logic [EVAL_W-1:0]              out_val_q;
  logic [tcsvl_pkg::POS_W-1:0]    out_pos_q;
  logic [tcsvl_pkg::COUNT_W-1:0]  out_count_q;

  // ram port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // scan compare
  logic             e_dens;
  logic [MAG_W-1:0] e_mag;
  logic [MAG_W-1:0] val_mag;
  logic             cls_break;
  logic             cls_skip;
  logic             hit_eq;
  logic             hit_gt;
  logic             last_entry;
  logic             scan_done;
  logic [CNT_W-1:0] scan_pos;
  logic             in_idx_bad;
  logic             up_dir;

  tcsvl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (tcsvl_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry under test against the new value
  assign e_dens     = ram_rdata[ENTRY_W-1];
  assign e_mag      = ram_rdata[MAG_W-1:0];
  assign val_mag    = MAG_W'(val_q);
  assign cls_break  = !dens_q && e_dens;
  assign cls_skip   = dens_q && !e_dens;
  assign hit_eq     = !cls_break && !cls_skip && (e_mag == val_mag);
  assign hit_gt     = !cls_break && !cls_skip && (e_mag > val_mag);
  assign last_entry = (ridx_q == count_q - CNT_W'(1));
  assign scan_done  = rvalid_q && (cls_break || hit_eq || hit_gt || last_entry);
  assign scan_pos   = (cls_break || hit_eq || hit_gt) ? ridx_q : count_q;
  assign in_idx_bad = CMP_W'(index_i) >= CMP_W'(count_q);
  assign up_dir     = (op_q == tcsvl_pkg::OP_INSERT);

  // status to the controller
  always_comb begin
    st_o            = '0;
    st_o.in_op      = operation_i;
    st_o.op         = op_q;
    st_o.in_idx_bad = in_idx_bad;
    st_o.cnt_zero   = (count_q == '0);
    st_o.full       = (count_q >= CNT_W'(tcsvl_pkg::CAPACITY));
    st_o.scan_done  = scan_done;
    st_o.scan_dup   = hit_eq;
    st_o.move_done  = (rem_q == '0) && !rvalid_q;
  end

  // datapath next state and ram access
  always_comb begin
    op_d         = op_q;
    dens_d       = dens_q;
    val_d        = val_q;
    idx_d        = idx_q;
    count_d      = count_q;
    pos_d        = pos_q;
    ptr_d        = ptr_q;
    rem_d        = rem_q;
    ridx_d       = ridx_q;
    rvalid_d     = 1'b0;
    res_status_d = res_status_q;
    res_dens_d   = res_dens_q;
    res_val_d    = res_val_q;
    res_pos_d    = res_pos_q;
    ram_we       = 1'b0;
    ram_waddr    = ADDR_W'(pos_q);
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = ADDR_W'(ptr_q);

    // capture a request and preset its result
    if (cmd_i.load) begin
      op_d   = operation_i;
      dens_d = is_density_i;
      val_d  = tcsvl_pkg::clamp_value(is_density_i, value_i);
      idx_d  = index_i;
      ptr_d  = '0;
      pos_d  = '0;
      res_dens_d = 1'b0;
      res_val_d  = '0;
      res_pos_d  = '0;
      case (operation_i) inside
        tcsvl_pkg::OP_INSERT: begin
          res_status_d = tcsvl_pkg::ST_OK;
          res_dens_d   = is_density_i;
          res_val_d    = tcsvl_pkg::clamp_value(is_density_i, value_i);
        end
        tcsvl_pkg::OP_DELETE, tcsvl_pkg::OP_READ: begin
          res_status_d = in_idx_bad ? tcsvl_pkg::ST_RANGE : tcsvl_pkg::ST_OK;
          res_pos_d    = tcsvl_pkg::POS_W'(index_i);
        end
        default: begin
          res_status_d = tcsvl_pkg::ST_RANGE;
        end
      endcase
    end

    // search for the insert position, one entry read per cycle
    if (cmd_i.scan) begin
      if (scan_done) begin
        pos_d     = scan_pos;
        res_pos_d = tcsvl_pkg::POS_W'(scan_pos);
        if (hit_eq) begin
          res_status_d = tcsvl_pkg::ST_DUP;
        end
      end else if (ptr_q < count_q) begin
        ram_re   = 1'b1;
        ram_raddr = ADDR_W'(ptr_q);
        rvalid_d = 1'b1;
        ridx_d   = ptr_q;
        ptr_d    = ptr_q + CNT_W'(1);
      end
    end

    // full table check, else arm the upward shift
    if (cmd_i.ins_setup) begin
      if (count_q >= CNT_W'(tcsvl_pkg::CAPACITY)) begin
        res_status_d = tcsvl_pkg::ST_FULL;
      end else begin
        rem_d = count_q - pos_q;
        ptr_d = count_q - CNT_W'(1);
      end
    end

    // shift entries one slot per cycle, read and write overlapped
    if (cmd_i.move) begin
      if (rem_q != '0) begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(ptr_q);
        rvalid_d  = 1'b1;
        ridx_d    = ptr_q;
        rem_d     = rem_q - CNT_W'(1);
        ptr_d     = up_dir ? (ptr_q - CNT_W'(1)) : (ptr_q + CNT_W'(1));
      end
      if (rvalid_q) begin
        ram_we    = 1'b1;
        ram_waddr = up_dir ? ADDR_W'(ridx_q + CNT_W'(1)) : ADDR_W'(ridx_q - CNT_W'(1));
        ram_wdata = ram_rdata;
      end
    end

    // place the new entry
    if (cmd_i.write_new) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(pos_q);
      ram_wdata = {dens_q, (ENTRY_W - 1 - EVAL_W)'(0), val_q};
      count_d   = count_q + CNT_W'(1);
    end

    // read the addressed entry
    if (cmd_i.rd_issue) begin
      ram_re    = 1'b1;
      ram_raddr = ADDR_W'(idx_q);
    end

    // report the entry, arm the downward shift for a delete
    if (cmd_i.rd_take) begin
      res_dens_d = e_dens;
      res_val_d  = e_dens ? EVAL_W'(ram_rdata[7:0]) : ram_rdata[EVAL_W-1:0];
      rem_d      = count_q - CNT_W'(1) - CNT_W'(idx_q);
      ptr_d      = CNT_W'(idx_q) + CNT_W'(1);
    end

    if (cmd_i.count_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    dens_q       <= dens_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    ptr_q        <= ptr_d;
    rem_q        <= rem_d;
    ridx_q       <= ridx_d;
    res_status_q <= res_status_d;
    res_dens_q   <= res_dens_d;
    res_val_q    <= res_val_d;
    res_pos_q    <= res_pos_d;
  end

  // output register, loaded on transfer into the result slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_dens_q   <= res_dens_q;
      out_val_q    <= res_val_q;
      out_pos_q    <= res_pos_q;
      out_count_q  <= tcsvl_pkg::COUNT_W'(count_q);
    end
  end

  assign status_o           = out_status_q;
  assign entry_is_density_o = out_dens_q;
  assign entry_value_o      = out_val_q;
  assign position_o         = out_pos_q;
  assign entry_count_o      = out_count_q;

  // checks
  `TCSVL_ASSERT_RST(a_count_in_range, clk_i, rst_ni, count_q <= CNT_W'(tcsvl_pkg::CAPACITY), "entry count above capacity")
  `TCSVL_ASSERT_RST(a_insert_grows, clk_i, rst_ni, cmd_i.write_new |=> count_q == $past(count_q) + 1'b1, "insert did not grow the table")
  `TCSVL_ASSERT_RST(a_write_in_table, clk_i, rst_ni, ram_we |-> CNT_W'(ram_waddr) <= count_q, "write beyond the used part of the table")

endmodule

// ===== design/two_class_sorted_value_list.sv =====
// top level of the two-class sorted value list
//
// Requests arrive on in_i (operation, is_density, value, index) and one
// result per request leaves on out_o (status, entry_is_density,
// entry_value, position, entry_count). Both are valid/ready channels; a
// transfer happens on a clock edge with valid and ready high.
// One request is worked on at a time and the next one can transfer in the
// same cycle as the result turns valid; in_i is ready whenever the block is
// idle, even while a finished result still waits in the output register.
// Steps per request: an unknown operation or an index out of range goes
// straight to the result; a read fetches the addressed entry; a delete
// fetches it and shifts the entries above it down; an insert searches for
// its place, stops on a duplicate or full table, else shifts up and writes.
// Insert and delete time is set by the single table ram, which gives one
// read and one write per cycle: the search reads one entry a cycle and the
// shift moves one entry a cycle.
// Reset empties the table at once; no clearing pass runs and a request may
// be sent in the first cycle after reset.
// If the receiver stalls, the result is held; the next request is still
// taken and processed, and its result waits until the output register frees.
`timescale 1ns / 1ps
module two_class_sorted_value_list (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcsvl_in_if.sink          in_i,
  tcsvl_out_if.source       out_o
);

  tcsvl_pkg::cmd_t cmd;
  tcsvl_pkg::st_t  st;
  logic            in_ready;
  logic            out_valid;

  // sequencer
  tcsvl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // table and result datapath
  tcsvl_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .st_o               (st),
    .operation_i        (in_i.operation),
    .is_density_i       (in_i.is_density),
    .value_i            (in_i.value),
    .index_i            (in_i.index),
    .status_o           (out_o.status),
    .entry_is_density_o (out_o.entry_is_density),
    .entry_value_o      (out_o.entry_value),
    .position_o         (out_o.position),
    .entry_count_o      (out_o.entry_count)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
